@@ design/xy_plotter_framebuffer_assert.svh @@
// Assertion macros for the XY plotter framebuffer.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef XY_PLOTTER_FRAMEBUFFER_ASSERT_SVH
`define XY_PLOTTER_FRAMEBUFFER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XYP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("xy plotter framebuffer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define XYP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("xy plotter framebuffer: next-cycle check failed");

`endif

@@ design/xyp_pkg.sv @@
// Shared constants, codes and types for the XY plotter framebuffer.
// No dependencies; used by every module of the block except xyp_ram.
package xyp_pkg;

   localparam int MAX_RES     = 256;
   localparam int RES_W       = $clog2(MAX_RES + 1);
   localparam int COORD_W     = $clog2(MAX_RES);
   localparam int STORE_DEPTH = MAX_RES * MAX_RES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PIX_W       = 24;
   localparam int CSR_IDX_W   = 2;

   localparam logic [RES_W-1:0] RES_RESET   = RES_W'(150);
   localparam logic [PIX_W-1:0] CLEAR_PIXEL = 24'h808080;

   localparam logic [CSR_IDX_W-1:0] REG_HSV_MODE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_XY_UNIPOLAR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_UNIPOLAR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RESOLUTION      = 2'd3;

   typedef enum logic [1:0] {
      CMD_PLOT  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Configuration as seen by the datapath; res is already clamped to 1..MAX_RES.
   typedef struct packed {
      logic             hsv_mode;
      logic             xy_unipolar;
      logic             colour_unipolar;
      logic [RES_W-1:0] res;
   } cfg_type;

   // Plot pipeline step enables, one hot while the plot is in ST_P1, ST_P2 or ST_P3, else all zero.
   typedef struct packed {
      logic p1;
      logic p2;
      logic p3;
   } step_type;

endpackage

@@ design/xyp_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module xyp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/xyp_map.sv @@
// Position mapping, grid check, store index and colour quantization.
// Depends on xyp_pkg.
module xyp_map (
   input  logic                         clock,
   input  xyp_pkg::cfg_type             cfg,
   input  xyp_pkg::step_type            step,
   input  logic signed [15:0]           x_sample,
   input  logic signed [15:0]           y_sample,
   input  logic signed [15:0]           colour_a,
   input  logic signed [15:0]           colour_b,
   input  logic signed [15:0]           colour_c,
   output logic                         on_grid,
   output logic [xyp_pkg::ADDR_W-1:0]   pix_index,
   output logic [7:0]                   byte_a,
   output logic [7:0]                   byte_b,
   output logic [7:0]                   byte_c
);

   localparam int PROD_W = 17 + xyp_pkg::RES_W + 1;
   localparam int MUL_W  = xyp_pkg::RES_W + xyp_pkg::COORD_W;

   // clamp at 0 and 255 after the unipolar/bipolar offset
   function automatic logic [7:0] quant(input logic signed [15:0] s, input logic uni);
      logic signed [16:0] t;
      t = uni ? {s[15], s} : {s[15], s} + 17'sd16384;
      if (t <= 17'sd0) begin
         quant = 8'd0;
      end else if (t[15]) begin
         quant = 8'hFF;
      end else begin
         quant = t[14:7];
      end
   endfunction

   logic signed [16:0]             base_x, base_y;
   logic signed [xyp_pkg::RES_W:0] res_s;
   logic signed [PROD_W-1:0]       prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [PROD_W-1:0]       sum_x, sum_y;
   logic [10:0]                    col_w, row_w;
   logic                           in_x, in_y;
   logic [MUL_W-1:0]               row_mul;
   logic [MUL_W-1:0]               index_full;
   logic                           on_grid_ff;
   logic [xyp_pkg::ADDR_W-1:0]     index_ff;
   logic [7:0]                     qa_ff, qb_ff, qc_ff;

   assign base_x = cfg.xy_unipolar ? {x_sample[15], x_sample}
                                   : {x_sample[15], x_sample} + 17'sd16384;
   assign base_y = cfg.xy_unipolar ? {y_sample[15], y_sample}
                                   : {y_sample[15], y_sample} + 17'sd16384;
   assign res_s  = signed'({1'b0, cfg.res});

   assign prod_x_in = PROD_W'(base_x) * PROD_W'(res_s);
   assign prod_y_in = PROD_W'(base_y) * PROD_W'(res_s);

   // Rounding half away from zero: a point is on the grid only when n + 0.5 is positive,
   // and then the coordinate is (n + 16384) >> 15.
   assign sum_x = prod_x_ff + PROD_W'(16384);
   assign sum_y = prod_y_ff + PROD_W'(16384);
   assign col_w = sum_x[25:15];
   assign row_w = sum_y[25:15];
   assign in_x  = !sum_x[PROD_W-1] && (sum_x != '0) && (col_w < 11'(cfg.res));
   assign in_y  = !sum_y[PROD_W-1] && (sum_y != '0) && (row_w < 11'(cfg.res));

   assign row_mul    = MUL_W'(row_w[xyp_pkg::COORD_W-1:0]) * MUL_W'(cfg.res);
   assign index_full = row_mul + MUL_W'(col_w[xyp_pkg::COORD_W-1:0]);

   always_ff @(posedge clock) begin
      if (step.p1) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         qa_ff     <= quant(colour_a, cfg.colour_unipolar);
         qb_ff     <= quant(colour_b, cfg.colour_unipolar);
         qc_ff     <= quant(colour_c, cfg.colour_unipolar);
      end
      if (step.p2) begin
         on_grid_ff <= in_x && in_y;
         index_ff   <= index_full[xyp_pkg::ADDR_W-1:0];
      end
   end

   assign on_grid   = on_grid_ff;
   assign pix_index = index_ff;
   assign byte_a    = qa_ff;
   assign byte_b    = qb_ff;
   assign byte_c    = qc_ff;

endmodule

@@ design/xyp_hsv.sv @@
// Fixed-point HSV to RGB conversion in three steps (sector, product, sum and scale).
// Depends on xyp_pkg.
module xyp_hsv (
   input  logic                       clock,
   input  xyp_pkg::step_type          step,
   input  logic [7:0]                 hue,
   input  logic [7:0]                 sat,
   input  logic [7:0]                 val,
   output logic [xyp_pkg::PIX_W-1:0]  pix
);

   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } sector_type;

   // (ch * 255) >> 24 without a multiplier
   function automatic logic [7:0] to_byte(input logic [23:0] ch);
      logic [31:0] p;
      p = {ch, 8'd0} - {8'd0, ch};
      to_byte = p[31:24];
   endfunction

   logic [10:0] h6;
   sector_type  sector_ff, sector2_ff;
   logic [7:0]  frac_ff, val_ff;
   logic [15:0] sv_ff;
   logic [8:0]  fsel;
   logic [24:0] xx_full;
   logic [23:0] xx_ff, cc_ff, mm_ff;
   logic [23:0] ch_r, ch_g, ch_b;

   assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

   assign fsel    = sector_ff[0] ? (9'd256 - {1'b0, frac_ff}) : {1'b0, frac_ff};
   assign xx_full = {9'd0, sv_ff} * {16'd0, fsel};

   always_ff @(posedge clock) begin
      if (step.p2) begin
         sector_ff <= sector_type'(h6[10:8]);
         frac_ff   <= h6[7:0];
         sv_ff     <= {8'd0, sat} * {8'd0, val};
         val_ff    <= val;
      end
      if (step.p3) begin
         sector2_ff <= sector_ff;
         xx_ff      <= xx_full[23:0];
         cc_ff      <= {sv_ff, 8'd0};
         mm_ff      <= {val_ff, 16'd0} - {sv_ff, 8'd0};
      end
   end

   always_comb begin
      case (sector2_ff)
         SEC_RY: begin ch_r = cc_ff; ch_g = xx_ff; ch_b = '0;    end
         SEC_YG: begin ch_r = xx_ff; ch_g = cc_ff; ch_b = '0;    end
         SEC_GC: begin ch_r = '0;    ch_g = cc_ff; ch_b = xx_ff; end
         SEC_CB: begin ch_r = '0;    ch_g = xx_ff; ch_b = cc_ff; end
         SEC_BM: begin ch_r = xx_ff; ch_g = '0;    ch_b = cc_ff; end
         default: begin ch_r = cc_ff; ch_g = '0;   ch_b = xx_ff; end
      endcase
   end

   assign pix = {to_byte(ch_r + mm_ff), to_byte(ch_g + mm_ff), to_byte(ch_b + mm_ff)};

endmodule

@@ design/xy_plotter_framebuffer.sv @@
// Channel | Direction | Handshake               | Payload
// req     | in        | req_tvalid / req_tready | tuser cmd, tdata samples and read address
// rsp     | out       | rsp_tvalid / rsp_tready | tuser written, tdata red, green, blue
// csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One item at a time. Plot: capture, product, round and index, HSV product, write;
// read: capture, index, memory read, result; clear: set-up, then res*res store writes,
// one store write per cycle through the single write port; cmd 3: capture and result.
// A stalled rsp holds the block in its last step; a new item is taken once the result
// sits in the output register. Reset clears control and configuration only: the
// store holds nothing defined until a clear has swept it.
// Depends on xyp_pkg, xyp_ram, xyp_map, xyp_hsv and the assertion header.
`include "xy_plotter_framebuffer_assert.svh"

module xy_plotter_framebuffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] x_sample, [31:16] y_sample, [47:32] colour_a, [63:48] colour_b,
   // [79:64] colour_c, [87:80] read_col, [95:88] read_row
   input  logic [95:0]                       req_tdata,
   // [1:0] cmd
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [23:0]                       rsp_tdata,
   // [0] written
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xyp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [xyp_pkg::RES_W-1:0]         csr_data
);

   localparam int MUL_W = xyp_pkg::RES_W + xyp_pkg::COORD_W;
   localparam int SQ_W  = 2 * xyp_pkg::RES_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_RIDX,
      ST_RMEM,
      ST_RDATA,
      ST_CLRSET,
      ST_CLEAR,
      ST_ZERO
   } state_type;

   // ---------------- configuration ----------------
   logic                      hsv_mode_ff, xy_unipolar_ff, colour_unipolar_ff;
   logic [xyp_pkg::RES_W-1:0] res_ff, res_in;
   xyp_pkg::cfg_type          cfg;

   assign csr_ready = 1'b1;

   // store the resolution already clamped to 1..MAX_RES
   always_comb begin
      if (csr_data == '0) begin
         res_in = xyp_pkg::RES_W'(1);
      end else if (csr_data > xyp_pkg::RES_W'(xyp_pkg::MAX_RES)) begin
         res_in = xyp_pkg::RES_W'(xyp_pkg::MAX_RES);
      end else begin
         res_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hsv_mode_ff        <= 1'b0;
         xy_unipolar_ff     <= 1'b0;
         colour_unipolar_ff <= 1'b0;
         res_ff             <= xyp_pkg::RES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            xyp_pkg::REG_HSV_MODE:        hsv_mode_ff        <= csr_data[0];
            xyp_pkg::REG_XY_UNIPOLAR:     xy_unipolar_ff     <= csr_data[0];
            xyp_pkg::REG_COLOUR_UNIPOLAR: colour_unipolar_ff <= csr_data[0];
            xyp_pkg::REG_RESOLUTION:      res_ff             <= res_in;
            default: ;
         endcase
      end
   end

   assign cfg = '{hsv_mode: hsv_mode_ff, xy_unipolar: xy_unipolar_ff,
                  colour_unipolar: colour_unipolar_ff, res: res_ff};

   // ---------------- control and datapath ----------------
   state_type                   state_ff, state_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic                        rsp_written_ff, rsp_written_in;
   logic [xyp_pkg::PIX_W-1:0]   rsp_pix_ff, rsp_pix_in;
   logic [xyp_pkg::ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [xyp_pkg::ADDR_W-1:0]  clr_last_ff, clr_last_in;
   logic [xyp_pkg::ADDR_W-1:0]  raddr_ff, raddr_in;
   logic                        rd_ok_ff, rd_ok_in;

   logic signed [15:0] x_ff, y_ff, ca_ff, cb_ff, cc_ff;
   logic [7:0]         col_ff, row_ff;

   logic                        out_free;
   logic                        req_fire;
   xyp_pkg::step_type           step;
   logic                        on_grid;
   logic [xyp_pkg::ADDR_W-1:0]  pix_index;
   logic [7:0]                  byte_a, byte_b, byte_c;
   logic [xyp_pkg::PIX_W-1:0]   hsv_pix, plot_pix;
   logic [MUL_W-1:0]            rd_mul;
   logic [SQ_W-1:0]             area;

   logic                        ram_we, ram_re;
   logic [xyp_pkg::ADDR_W-1:0]  ram_waddr;
   logic [xyp_pkg::PIX_W-1:0]   ram_wdata, ram_rdata;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign step = '{p1: state_ff == ST_P1, p2: state_ff == ST_P2, p3: state_ff == ST_P3};

   xyp_map u_map (
      .clock     (clock),
      .cfg       (cfg),
      .step      (step),
      .x_sample  (x_ff),
      .y_sample  (y_ff),
      .colour_a  (ca_ff),
      .colour_b  (cb_ff),
      .colour_c  (cc_ff),
      .on_grid   (on_grid),
      .pix_index (pix_index),
      .byte_a    (byte_a),
      .byte_b    (byte_b),
      .byte_c    (byte_c)
   );

   xyp_hsv u_hsv (
      .clock (clock),
      .step  (step),
      .hue   (byte_a),
      .sat   (byte_b),
      .val   (byte_c),
      .pix   (hsv_pix)
   );

   assign plot_pix = cfg.hsv_mode ? hsv_pix : {byte_a, byte_b, byte_c};

   // Writes happen only in the last plot step or the clear sweep, and a read is issued
   // only after the previous item has finished, so no access overlaps another.
   assign ram_we    = ((state_ff == ST_P4) && on_grid) || (state_ff == ST_CLEAR);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : pix_index;
   assign ram_wdata = (state_ff == ST_CLEAR) ? xyp_pkg::CLEAR_PIXEL : plot_pix;
   assign ram_re    = (state_ff == ST_RMEM);

   xyp_ram #(
      .WIDTH (xyp_pkg::PIX_W),
      .DEPTH (xyp_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (raddr_ff),
      .rdata (ram_rdata)
   );

   assign rd_mul   = MUL_W'(row_ff) * MUL_W'(cfg.res) + MUL_W'(col_ff);
   assign raddr_in = rd_mul[xyp_pkg::ADDR_W-1:0];
   assign rd_ok_in = (xyp_pkg::RES_W'(col_ff) < cfg.res) && (xyp_pkg::RES_W'(row_ff) < cfg.res);
   assign area     = SQ_W'(cfg.res) * SQ_W'(cfg.res) - SQ_W'(1);

   always_comb begin
      state_in       = state_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_written_in = rsp_written_ff;
      rsp_pix_in     = rsp_pix_ff;
      clr_cnt_in     = clr_cnt_ff;
      clr_last_in    = clr_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (xyp_pkg::cmd_type'(req_tuser))
                  xyp_pkg::CMD_PLOT:  state_in = ST_P1;
                  xyp_pkg::CMD_CLEAR: state_in = ST_CLRSET;
                  xyp_pkg::CMD_READ:  state_in = ST_RIDX;
                  default:            state_in = ST_ZERO;
               endcase
            end
         end
         ST_P1: state_in = ST_P2;
         ST_P2: state_in = ST_P3;
         ST_P3: state_in = ST_P4;
         ST_P4: begin
            // hold here while rsp is stalled; rewriting the same pixel is harmless
            if (out_free) begin
               rsp_tvalid_in  = 1'b1;
               rsp_written_in = on_grid;
               rsp_pix_in     = on_grid ? plot_pix : '0;
               state_in       = ST_IDLE;
            end
         end
         ST_RIDX: state_in = ST_RMEM;
         ST_RMEM: state_in = ST_RDATA;
         ST_RDATA: begin
            if (out_free) begin
               rsp_tvalid_in  = 1'b1;
               rsp_written_in = 1'b0;
               rsp_pix_in     = rd_ok_ff ? ram_rdata : '0;
               state_in       = ST_IDLE;
            end
         end
         ST_CLRSET: begin
            clr_cnt_in  = '0;
            clr_last_in = area[xyp_pkg::ADDR_W-1:0];
            state_in    = ST_CLEAR;
         end
         ST_CLEAR: begin
            if (clr_cnt_ff == clr_last_ff) begin
               state_in = ST_ZERO;
            end else begin
               clr_cnt_in = clr_cnt_ff + xyp_pkg::ADDR_W'(1);
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_tvalid_in  = 1'b1;
               rsp_written_in = 1'b0;
               rsp_pix_in     = '0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_written_ff <= rsp_written_in;
      rsp_pix_ff     <= rsp_pix_in;
      clr_cnt_ff     <= clr_cnt_in;
      clr_last_ff    <= clr_last_in;
      if (req_fire) begin
         x_ff   <= req_tdata[15:0];
         y_ff   <= req_tdata[31:16];
         ca_ff  <= req_tdata[47:32];
         cb_ff  <= req_tdata[63:48];
         cc_ff  <= req_tdata[79:64];
         col_ff <= req_tdata[87:80];
         row_ff <= req_tdata[95:88];
      end
      if (state_ff == ST_RIDX) begin
         raddr_ff <= raddr_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_written_ff;
   assign rsp_tdata  = {rsp_pix_ff[7:0], rsp_pix_ff[15:8], rsp_pix_ff[23:16]};

   // ---------------- checks ----------------
   `XYP_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != ST_IDLE)
   `XYP_ASSERT_NOW(a_no_write_while_ready, ram_we, !req_tready)
   `XYP_ASSERT_NOW(a_clear_in_bounds, state_ff == ST_CLEAR, clr_cnt_ff <= clr_last_ff)

endmodule
